// ===== hw/rtl/sbwp_pkg.sv =====
// shared types, codes and constants for the sub-byte weight packer
package sbwp_pkg;

    // sizing constants
    localparam int RUN_COUNT_BITS     = 16;
    localparam int MAX_CONTAINER_BITS = 32;
    localparam int ITEM_W             = 8;
    localparam int WORD_W             = 32;
    localparam int FILL_W             = 6;
    localparam int CNT_W              = 3;

    // operating modes
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_NARROW = 2'd1;
    localparam logic [1:0] MODE_PACK   = 2'd2;

    // container size codes
    localparam logic [1:0] CS_8  = 2'd0;
    localparam logic [1:0] CS_16 = 2'd1;
    localparam logic [1:0] CS_32 = 2'd2;

    // register indexes (byte address bits 3:2)
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_ITEM_BITS = 2'd1;
    localparam logic [1:0] REG_CONT_SIZE = 2'd2;
    localparam logic [1:0] REG_RUN_LEN   = 2'd3;

    // configuration register set
    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  item_bits;
        logic [1:0]  container_size;
        logic [15:0] run_length;
    } cfg_t;

    // bytes produced by one item, low byte first
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [WORD_W-1:0] word;
    } res_t;

endpackage

// ===== hw/rtl/sbwp_pack_core.sv =====
// packing state and per-item result logic
module sbwp_pack_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbwp_pkg::cfg_t              cfg,
    input  logic                        step,
    input  logic [sbwp_pkg::ITEM_W-1:0] item_value,
    input  logic                        last_item,
    output sbwp_pkg::res_t              res
);
    import sbwp_pkg::*;

    logic [WORD_W-1:0]         word_reg, word_next;
    logic [FILL_W-1:0]         filled_reg, filled_next;
    logic [RUN_COUNT_BITS-1:0] rpos_reg, rpos_next;

    logic [3:0]                keep_bits;
    logic [ITEM_W-1:0]         keep_mask;
    logic [ITEM_W-1:0]         masked;
    logic                      narrow;
    logic                      pack;
    logic [FILL_W-1:0]         cbits;
    logic [WORD_W-1:0]         word_sum;
    logic [FILL_W:0]           filled_sum;
    logic [FILL_W+1:0]         fill_test;
    logic [RUN_COUNT_BITS-1:0] rend;
    logic                      run_end;
    logic                      flush;

    // item masking
    always_comb
    begin
        keep_bits = (cfg.item_bits > 4'd8) ? 4'd8 : cfg.item_bits;
        keep_mask = ITEM_W'((9'd1 << keep_bits) - 9'd1);
        masked    = item_value & keep_mask;
        narrow    = (cfg.mode == MODE_NARROW) ||
                    ((cfg.mode == MODE_PACK) && (cfg.container_size == 2'd3));
        pack      = (cfg.mode == MODE_PACK) && (cfg.container_size != 2'd3);
    end

    // container width, limited to the widest container
    always_comb
    begin
        case (cfg.container_size)
            CS_8:    cbits = FILL_W'(8);
            CS_16:   cbits = FILL_W'(16);
            CS_32:   cbits = FILL_W'(32);
            default: cbits = FILL_W'(8);
        endcase
        if (cbits > FILL_W'(MAX_CONTAINER_BITS))
        begin
            cbits = FILL_W'(MAX_CONTAINER_BITS);
        end
    end

    // accumulate and decide on a flush
    always_comb
    begin
        word_sum   = word_reg | (WORD_W'(masked) << filled_reg);
        filled_sum = {1'b0, filled_reg} + (FILL_W+1)'(keep_bits);
        fill_test  = {1'b0, filled_sum} + (FILL_W+2)'(keep_bits);
        rend       = RUN_COUNT_BITS'(cfg.run_length - 16'd1);
        run_end    = (rpos_reg == rend);
        flush      = (fill_test > (FILL_W+2)'(cbits)) || run_end || last_item;
    end

    // result for this item and next packing state
    always_comb
    begin
        word_next   = word_reg;
        filled_next = filled_reg;
        rpos_next   = rpos_reg;
        res.cnt     = CNT_W'(1);
        res.word    = WORD_W'(item_value);
        if (narrow)
        begin
            res.word = WORD_W'(masked);
        end
        else if (pack)
        begin
            rpos_next = rpos_reg + RUN_COUNT_BITS'(1);
            if (flush)
            begin
                res.cnt     = CNT_W'(cbits >> 3);
                res.word    = word_sum;
                word_next   = '0;
                filled_next = '0;
                if (run_end || last_item)
                begin
                    rpos_next = '0;
                end
            end
            else
            begin
                res.cnt     = '0;
                word_next   = word_sum;
                filled_next = filled_sum[FILL_W-1:0];
            end
        end
    end

    // packing state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg   <= '0;
            filled_reg <= '0;
            rpos_reg   <= '0;
        end
        else if (step)
        begin
            word_reg   <= word_next;
            filled_reg <= filled_next;
            rpos_reg   <= rpos_next;
        end
    end

endmodule

// ===== hw/rtl/sub_byte_weight_packer.sv =====
// top level of the sub-byte weight packer: config port, input and output stages
// Usage:
//   s_* channel carries one quantized byte per transaction; s_tlast marks the
//   final item of a tensor. m_* channel returns output bytes, containers low
//   byte first, with m_tlast on the last byte of each container or single byte.
//   Registers (APB, byte address 4*i): mode, item_bits, container_size,
//   run_length. Write them only while the block is idle.
// Pipeline: an accepted item is held in the input register until the output
//   register can take it; the core result is then registered there and offered.
// Throughput: one item per cycle while m_tready is high and each item yields at
//   most one byte. A flushed container of n bytes leaves the output register
//   one byte per cycle while m_tready is high; the input side stalls meanwhile.
// Reset: registers return to pass-through, 8-bit items, 8-bit containers,
//   run length 1; the container, fill count and run position are cleared.
// Stall: when m_tready is low the output byte holds, the input register fills
//   and s_tready drops; no transaction is lost or repeated.
module sub_byte_weight_packer (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] item_value
    input  logic        s_tlast,   // last_item
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // end_of_group
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbwp_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [ITEM_W-1:0] in_value_reg;
    logic              in_last_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [WORD_W-1:0] out_data_reg;
    logic              advance;
    logic              cfg_write;
    res_t              res;

    // register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= MODE_PASS;
            cfg_reg.item_bits      <= 4'd8;
            cfg_reg.container_size <= CS_8;
            cfg_reg.run_length     <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_MODE:      cfg_reg.mode           <= pwdata[1:0];
                REG_ITEM_BITS: cfg_reg.item_bits      <= pwdata[3:0];
                REG_CONT_SIZE: cfg_reg.container_size <= pwdata[1:0];
                REG_RUN_LEN:   cfg_reg.run_length     <= pwdata[15:0];
                default:       cfg_reg.mode           <= cfg_reg.mode;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:      prdata = 32'(cfg_reg.mode);
            REG_ITEM_BITS: prdata = 32'(cfg_reg.item_bits);
            REG_CONT_SIZE: prdata = 32'(cfg_reg.container_size);
            REG_RUN_LEN:   prdata = 32'(cfg_reg.run_length);
            default:       prdata = '0;
        endcase
    end

    // item moves on when the output register is empty or draining its last byte
    assign advance  = in_valid_reg &&
                      ((out_cnt_reg == '0) || ((out_cnt_reg == CNT_W'(1)) && m_tready));
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_value_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
    end

    sbwp_pack_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .step       (advance),
        .item_value (in_value_reg),
        .last_item  (in_last_reg),
        .res        (res)
    );

    // output byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
        end
        else if (advance)
        begin
            out_cnt_reg <= res.cnt;
        end
        else if (m_tvalid && m_tready)
        begin
            out_cnt_reg <= out_cnt_reg - CNT_W'(1);
        end
    end

    // output data, shifted down one byte per transaction
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res.word;
        end
        else if (m_tvalid && m_tready)
        begin
            out_data_reg <= out_data_reg >> 8;
        end
    end

    assign m_tvalid = (out_cnt_reg != '0);
    assign m_tdata  = out_data_reg[7:0];
    assign m_tlast  = (out_cnt_reg == CNT_W'(1));

endmodule

// ===== tb/tb_sub_byte_weight_packer.sv =====
// self-checking testbench for the sub-byte weight packer stream block
`timescale 1ns / 1ps

module tb_sub_byte_weight_packer;
    import sbwp_pkg::*;

    // codes that the package leaves unnamed
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] CS_UNUSED   = 2'd3;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int SEGS_PER_PHASE  = 4;
    localparam int ITEMS_PER_SEG   = 12;

    // one output byte as the block should send it
    typedef struct {
        logic [7:0] value;
        logic       group_end;
    } packed_byte_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] item_value
    logic        s_tlast  = 1'b0;    // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic        m_tlast;            // end_of_group
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // register copy and packing state of the predictor
    logic [1:0]  cfg_mode      = MODE_PASS;
    logic [3:0]  cfg_item_bits = 4'd8;
    logic [1:0]  cfg_cont_size = CS_8;
    logic [15:0] cfg_run_len   = 16'd1;
    logic [31:0] acc_word      = 32'h0;
    logic [5:0]  acc_fill      = 6'd0;
    logic [15:0] run_idx       = 16'd0;

    packed_byte_t pending_bytes[$];
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    sub_byte_weight_packer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // random back-pressure on the output
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // append one expected byte to the tail of the queue
    function automatic void queue_byte(input logic [7:0] value, input logic group_end);
        packed_byte_t b;
        b.value     = value;
        b.group_end = group_end;
        pending_bytes.insert(pending_bytes.size(), b);
    endfunction

    // work out the bytes one accepted item should produce
    function automatic void pack_predict(input logic [7:0] v, input logic last);
        int unsigned eff;
        int unsigned cbits;
        int unsigned fill;
        int unsigned nbytes;
        logic [7:0]  keep;
        logic [31:0] word;
        logic [15:0] rpos;
        logic        run_end;
        eff  = (cfg_item_bits > 4'd8) ? 8 : cfg_item_bits;
        keep = 8'((9'd1 << eff) - 9'd1);
        // narrow mode, also pack mode with the unused container code
        if (cfg_mode == MODE_NARROW || (cfg_mode == MODE_PACK && cfg_cont_size == CS_UNUSED))
        begin
            queue_byte(v & keep, 1'b1);
            return;
        end
        // pass-through, also the unused mode code
        if (cfg_mode != MODE_PACK)
        begin
            queue_byte(v, 1'b1);
            return;
        end
        case (cfg_cont_size)
            CS_8:    cbits = 8;
            CS_16:   cbits = 16;
            default: cbits = 32;
        endcase
        if (cbits > MAX_CONTAINER_BITS)
            cbits = MAX_CONTAINER_BITS;
        word = acc_word | 32'(64'(v & keep) << acc_fill);
        fill = acc_fill + eff;
        // run counter wraps at its width, so a run length of zero is a full wrap
        rpos    = run_idx;
        run_end = (rpos == 16'(cfg_run_len - 16'd1));
        run_idx = 16'(rpos + 16'd1);
        // flush when the next item would not fit, at run end or on the last item
        if (fill + eff > cbits || run_end || last)
        begin
            nbytes = cbits / 8;
            for (int k = 0; k < nbytes; k++)
                queue_byte(word[8*k +: 8], (k == nbytes - 1));
            word = 32'h0;
            fill = 0;
            if (run_end || last)
                run_idx = 16'd0;
        end
        acc_word = word;
        acc_fill = 6'(fill);
    endfunction

    task automatic report_mismatch(input string field, input int exp_v, input int act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected 0x%0h, got 0x%0h",
                     $realtime, field, exp_v, act_v);
    endtask

    // compare each output transaction with the oldest predicted byte
    always @(posedge clk)
    begin : check_output
        packed_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch("unexpected byte", 0, m_tdata);
            else
            begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch("out_byte", want.value, m_tdata);
                if (m_tlast !== want.group_end)
                    report_mismatch("end_of_group", want.group_end, m_tlast);
            end
        end
    end

    // send one item, idling first at the current rate
    task automatic send_item(input logic [7:0] v, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pack_predict(v, last);
    endtask

    // let every predicted byte drain, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write: setup cycle then access cycle
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_MODE:      cfg_mode      = val[1:0];
            REG_ITEM_BITS: cfg_item_bits = val[3:0];
            REG_CONT_SIZE: cfg_cont_size = val[1:0];
            default:       cfg_run_len   = val[15:0];
        endcase
    endtask

    task automatic configure(input logic [1:0] mode, input logic [3:0] bits,
                             input logic [1:0] cs, input logic [15:0] run_len);
        wait_idle();
        reg_write(REG_MODE, {30'h0, mode});
        reg_write(REG_ITEM_BITS, {28'h0, bits});
        reg_write(REG_CONT_SIZE, {30'h0, cs});
        reg_write(REG_RUN_LEN, {16'h0, run_len});
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // pass-through and the unused mode code
    task automatic test_pass_modes();
        configure(MODE_PASS, 4'd8, CS_8, 16'd1);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        configure(MODE_UNUSED, 4'd3, CS_16, 16'd1);
        send_item(8'ha5, 1'b0);
    endtask

    // narrow mode at widths 1 and 4, wide and zero widths, unused container
    task automatic test_narrow_widths();
        configure(MODE_NARROW, 4'd1, CS_8, 16'd1);
        send_item(8'hff, 1'b0);
        configure(MODE_NARROW, 4'd4, CS_8, 16'd1);
        send_item(8'h3c, 1'b1);
        configure(MODE_NARROW, 4'd15, CS_8, 16'd1);
        send_item(8'h96, 1'b0);
        configure(MODE_NARROW, 4'd0, CS_8, 16'd1);
        send_item(8'hff, 1'b0);
        configure(MODE_PACK, 4'd3, CS_UNUSED, 16'd1);
        send_item(8'hff, 1'b0);
    endtask

    // flush on a full container, on the last item and on run end
    task automatic test_pack_containers();
        configure(MODE_PACK, 4'd4, CS_16, 16'd0);
        send_item(8'hf1, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h03, 1'b0);
        send_item(8'h84, 1'b0);
        send_item(8'h5f, 1'b1);
        configure(MODE_PACK, 4'd8, CS_32, 16'd3);
        send_item(8'h11, 1'b0);
        send_item(8'h22, 1'b0);
        send_item(8'h33, 1'b0);
        configure(MODE_PACK, 4'd7, CS_8, 16'd65535);
        send_item(8'h7f, 1'b0);
        send_item(8'h80, 1'b0);
    endtask

    // zero width items only flush at run end
    task automatic test_zero_width();
        configure(MODE_PACK, 4'd0, CS_8, 16'd2);
        send_item(8'hff, 1'b0);
        send_item(8'hff, 1'b0);
    endtask

    // a narrow item in the middle leaves the partial container alone
    task automatic test_mode_switch();
        configure(MODE_PACK, 4'd2, CS_8, 16'd0);
        send_item(8'h03, 1'b0);
        configure(MODE_NARROW, 4'd2, CS_8, 16'd0);
        send_item(8'hff, 1'b0);
        configure(MODE_PACK, 4'd2, CS_8, 16'd0);
        send_item(8'h01, 1'b1);
    endtask

    // random settings, mostly pack mode with short runs
    task automatic test_random_traffic(input int idle_pct, input int stalls);
        logic [1:0]  mode;
        logic [3:0]  bits;
        logic [1:0]  cs;
        logic [15:0] run_len;
        int          pick;
        send_idle_pct = idle_pct;
        stall_pct     = stalls;
        for (int seg = 0; seg < SEGS_PER_PHASE; seg++)
        begin
            pick = $urandom_range(9);
            if (pick < 6)
                mode = MODE_PACK;
            else if (pick < 8)
                mode = MODE_NARROW;
            else if (pick == 8)
                mode = MODE_PASS;
            else
                mode = MODE_UNUSED;
            bits = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
            cs   = ($urandom_range(9) == 0) ? CS_UNUSED : 2'($urandom_range(2));
            pick = $urandom_range(9);
            if (pick == 0)
                run_len = 16'd0;
            else if (pick == 1)
                run_len = 16'hffff;
            else if (pick == 2)
                run_len = 16'($urandom_range(65535));
            else
                run_len = 16'($urandom_range(1, 12));
            configure(mode, bits, cs, run_len);
            for (int i = 0; i < ITEMS_PER_SEG; i++)
                send_item(8'($urandom_range(255)), ($urandom_range(9) == 0));
        end
    endtask

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pass_modes();
        test_narrow_widths();
        test_pack_containers();
        test_zero_width();
        test_mode_switch();
        test_random_traffic(0, 0);
        test_random_traffic(84, 0);
        test_random_traffic(0, 84);
        test_random_traffic(16, 16);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_bytes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sbwp_pkg.sv
hw/rtl/sbwp_pack_core.sv
hw/rtl/sub_byte_weight_packer.sv
tb/tb_sub_byte_weight_packer.sv
